@@ rtl/kmm_pkg.sv @@
// ----------------------------------------------------------------------------
// kmm_pkg
// Shared constants, codes and types of the k-mer Markov model trainer.
// ----------------------------------------------------------------------------
package kmm_pkg;

   localparam int MAX_WINDOW_DEF = 6;
   localparam int COUNT_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int QUERY_W  = 13;
   localparam int LOGP_W   = 22;
   localparam int ORDER_W  = 3;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd2;

   localparam int LOG_FRAC = 28;
   localparam int MANT_W   = 31;
   localparam int LN2_W    = 30;
   localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;
   localparam logic [LOGP_W-1:0] MAG_MAX = 22'h200000;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_SEL_ORDER = 1'b0;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] HDR_CHAR = 8'h3E;
   localparam logic [7:0] NL_CHAR  = 8'h0A;

   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_HEADER,
      PH_SEQ
   } phase_type;

   typedef enum logic [1:0] {
      SYM_BASE,
      SYM_NBREAK,
      SYM_OTHER
   } sym_kind_type;

   typedef struct packed {
      sym_kind_type kind;
      logic [1:0]   base;
   } sym_type;

   typedef enum logic [1:0] {
      QK_TRANS,
      QK_INIT,
      QK_BAD
   } qkind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INC_RD,
      ST_INC_WR,
      ST_Q_RD,
      ST_LNUM_GO,
      ST_LNUM_WAIT,
      ST_LDEN_GO,
      ST_LDEN_WAIT,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DONE
   } back_state_type;

   typedef enum logic [1:0] {
      LG_IDLE,
      LG_NORM,
      LG_SQ,
      LG_DONE
   } log_state_type;

   function automatic sym_type kmm_decode(input logic [7:0] ch);
      sym_type s;
      s.kind = SYM_OTHER;
      s.base = 2'd0;
      case (ch) inside
         8'h41, 8'h61: begin
            s.kind = SYM_BASE;
            s.base = 2'd0;
         end
         8'h54, 8'h74: begin
            s.kind = SYM_BASE;
            s.base = 2'd1;
         end
         8'h47, 8'h67: begin
            s.kind = SYM_BASE;
            s.base = 2'd2;
         end
         8'h43, 8'h63: begin
            s.kind = SYM_BASE;
            s.base = 2'd3;
         end
         8'h4E, 8'h6E: begin
            s.kind = SYM_NBREAK;
         end
         default: begin
            s.kind = SYM_OTHER;
         end
      endcase
      return s;
   endfunction

endpackage

@@ rtl/kmm_ifs.sv @@
// ----------------------------------------------------------------------------
// kmm_ifs
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kmm_req_if import kmm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [7:0]         file_byte;
   logic [QUERY_W-1:0] query_index;

   modport source (output valid, cmd, file_byte, query_index, input ready);
   modport sink   (input valid, cmd, file_byte, query_index, output ready);
endinterface

interface kmm_rsp_if import kmm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [QUERY_W-1:0]       entry_index;
   logic signed [LOGP_W-1:0] log_prob;
   logic                     bad_index;

   modport source (output valid, entry_index, log_prob, bad_index, input ready);
   modport sink   (input valid, entry_index, log_prob, bad_index, output ready);
endinterface

@@ rtl/kmer_markov_model_trainer_core.sv @@
// ----------------------------------------------------------------------------
// kmer_markov_model_trainer_core
// Trains k-mer Markov counts from a FASTA byte stream and answers
// Laplace-smoothed log-probability queries in signed Q6.16.
//
// req_chan carries one beat per file byte (cmd 0) or per query (cmd 1); file
// bytes give no response, every query gives exactly one beat on rsp_chan.
// csr_* is an APB write/read port holding the Markov order at address 0.
// A base that completes a window costs a back-end queue pop, a table read and a
// table write. An in-range query is popped, reads the table (four sibling
// entries, or one for an initial entry), runs two passes of the log2 unit
// (normalize, then one squaring per fraction bit), the multiply steps MUL_LO
// and MUL_HI and an output load; an out-of-range query goes straight to it.
// After reset the count tables are swept to zero, one entry per cycle, over
// 2^(2*MAX_WINDOW) entries (4096 by default); req_chan.ready stays low then.
// A stalled rsp_chan holds its beat in the output register; the back end waits
// and the front keeps accepting bytes until the four-entry queue is full.
// ----------------------------------------------------------------------------
module kmer_markov_model_trainer_core import kmm_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   kmm_req_if.sink               req_chan,
   kmm_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int HW   = 2 * MAX_WINDOW;
   localparam int SW   = (MAX_WINDOW > 1) ? 2 * (MAX_WINDOW - 1) : 1;
   localparam int OP_W = 3 + HW + SW + 2 + QUERY_W;

   logic [ORDER_W-1:0] order_ff, order_in;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   logic [OP_W-1:0]    q_wdata;
   logic [OP_W-1:0]    q_rdata;
   logic               clearing;
   logic               csr_sel_order;

   assign csr_pready    = 1'b1;
   assign csr_sel_order = (csr_paddr[CSR_ADDR_W-1] == CSR_SEL_ORDER);
   assign csr_prdata    = csr_sel_order ? CSR_DATA_W'(order_ff) : '0;

   always_comb begin
      order_in = order_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_order) begin
         order_in = csr_pwdata[ORDER_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
      end else begin
         order_ff <= order_in;
      end
   end

   kmm_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .markov_order (order_ff),
      .clearing     (clearing),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_wdata)
   );

   kmm_queue #(
      .WIDTH (OP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .head_data (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   kmm_back #(
      .MAX_WINDOW (MAX_WINDOW),
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rdata),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp      (rsp_chan)
   );

endmodule

@@ rtl/kmm_queue.sv @@
// ----------------------------------------------------------------------------
// kmm_queue
// Small register fifo between the parser front and the count/query back end.
// ----------------------------------------------------------------------------
module kmm_queue import kmm_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;

   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/kmm_front.sv @@
// ----------------------------------------------------------------------------
// kmm_front
// Parses the file byte stream, tracks base history and classifies queries.
// ----------------------------------------------------------------------------
module kmm_front import kmm_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   localparam int HW    = 2 * MAX_WINDOW,
   localparam int SW    = (MAX_WINDOW > 1) ? 2 * (MAX_WINDOW - 1) : 1,
   localparam int VW    = $clog2(MAX_WINDOW + 1),
   localparam int CMP_W = ((2 * MAX_WINDOW + 1 > QUERY_W) ? 2 * MAX_WINDOW + 1 : QUERY_W) + 1,
   localparam int OP_W  = 3 + HW + SW + 2 + QUERY_W
) (
   input  logic               clock,
   input  logic               reset,
   kmm_req_if.sink            req,
   input  logic [ORDER_W-1:0] markov_order,
   input  logic               clearing,
   input  logic               q_full,
   output logic               q_push,
   output logic [OP_W-1:0]    q_data
);

   typedef struct packed {
      logic               is_query;
      logic               long_en;
      logic               short_en;
      logic [HW-1:0]      long_idx;
      logic [SW-1:0]      short_idx;
      qkind_type          qkind;
      logic [QUERY_W-1:0] qindex;
   } op_type;

   phase_type     phase_ff, phase_in;
   logic [HW-1:0] hist_ff, hist_in;
   logic [VW-1:0] run_ff, run_in;

   logic               accept;
   logic               is_byte;
   sym_type            sym;
   logic [ORDER_W-1:0] eff;
   logic [3:0]         len;
   logic [HW-1:0]      hist_shift;
   logic [VW-1:0]      run_inc;
   logic               long_en;
   logic               short_en;
   logic               take_base;
   logic               take_n;
   logic [CMP_W-1:0]   idx_ext;
   logic [CMP_W-1:0]   nl;
   logic [CMP_W-1:0]   ns;
   op_type             op;

   assign req.ready = !q_full && !clearing;
   assign accept    = req.valid && req.ready;
   assign is_byte   = (req.cmd == CMD_BYTE);
   assign sym       = kmm_decode(req.file_byte);

   assign eff = ({1'b0, markov_order} > 4'(MAX_WINDOW - 1)) ? ORDER_W'(MAX_WINDOW - 1)
                                                             : markov_order;
   assign len = 4'(eff) + 4'd1;

   assign hist_shift = HW'({hist_ff, sym.base});
   assign run_inc    = (run_ff < VW'(MAX_WINDOW)) ? run_ff + 1'b1 : run_ff;
   assign long_en    = (5'(run_inc) >= 5'(len));
   assign short_en   = (eff != '0) && (5'(run_inc) >= 5'(eff));

   assign idx_ext = CMP_W'(req.query_index);
   assign nl      = CMP_W'(1) << {len, 1'b0};
   assign ns      = CMP_W'(1) << {eff, 1'b0};

   // next state of the parser
   always_comb begin
      phase_in = phase_ff;
      if (accept && is_byte) begin
         unique case (phase_ff)
            PH_FIRST: begin
               phase_in = (req.file_byte == HDR_CHAR) ? PH_HEADER : PH_SEQ;
            end
            PH_HEADER: begin
               if (req.file_byte == NL_CHAR) begin
                  phase_in = PH_SEQ;
               end
            end
            PH_SEQ: begin
               phase_in = PH_SEQ;
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase
      end
   end

   // parser outputs
   always_comb begin
      take_base = accept && is_byte && (phase_ff == PH_SEQ) && (sym.kind == SYM_BASE);
      take_n    = accept && is_byte && (phase_ff == PH_SEQ) && (sym.kind == SYM_NBREAK);
   end

   always_comb begin
      hist_in = hist_ff;
      run_in  = run_ff;
      if (take_base) begin
         hist_in = hist_shift;
         run_in  = run_inc;
      end else if (take_n) begin
         run_in = '0;
      end
   end

   always_comb begin
      op.qindex = req.query_index;
      if (accept && !is_byte) begin
         op.is_query  = 1'b1;
         op.long_en   = 1'b0;
         op.short_en  = 1'b0;
         op.long_idx  = HW'(idx_ext);
         op.short_idx = SW'(idx_ext - nl);
         if (idx_ext < nl) begin
            op.qkind = QK_TRANS;
         end else if ((eff != '0) && (idx_ext < nl + ns)) begin
            op.qkind = QK_INIT;
         end else begin
            op.qkind = QK_BAD;
         end
      end else begin
         op.is_query  = 1'b0;
         op.long_en   = long_en;
         op.short_en  = short_en;
         op.long_idx  = hist_shift & ~({HW{1'b1}} << {len, 1'b0});
         op.short_idx = SW'(hist_shift & ~({HW{1'b1}} << {eff, 1'b0}));
         op.qkind     = QK_BAD;
      end
   end

   assign q_push = (take_base && (long_en || short_en)) || (accept && !is_byte);
   assign q_data = op;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         hist_ff  <= '0;
         run_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         hist_ff  <= hist_in;
         run_ff   <= run_in;
      end
   end

endmodule

@@ rtl/kmm_log.sv @@
// ----------------------------------------------------------------------------
// kmm_log
// Iterative log2 unit: bit-serial normalize, then one squaring per fraction bit.
// ----------------------------------------------------------------------------
module kmm_log import kmm_pkg::*; #(
   parameter int XW = 35,
   localparam int PW   = $clog2(XW),
   localparam int LOGW = PW + LOG_FRAC,
   localparam int STW  = $clog2(LOG_FRAC)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [XW-1:0]   x,
   output logic            done,
   output logic [LOGW-1:0] result
);

   log_state_type         state_ff, state_in;
   logic [XW-1:0]         x_ff;
   logic [PW-1:0]         p_ff;
   logic [MANT_W-1:0]     m_ff;
   logic [LOG_FRAC-1:0]   frac_ff;
   logic [STW-1:0]        step_ff;

   logic [XW+MANT_W-1:0]  wide;
   logic [2*MANT_W-1:0]   sq;
   logic [MANT_W:0]       s;

   assign wide = {x_ff, {MANT_W{1'b0}}};
   assign sq   = m_ff * m_ff;
   assign s    = sq[2*MANT_W-1:MANT_W-1];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LG_IDLE: begin
            if (start) begin
               state_in = LG_NORM;
            end
         end
         LG_NORM: begin
            if (x_ff[XW-1]) begin
               state_in = LG_SQ;
            end
         end
         LG_SQ: begin
            if (step_ff == STW'(LOG_FRAC - 1)) begin
               state_in = LG_DONE;
            end
         end
         LG_DONE: begin
            state_in = LG_IDLE;
         end
         default: begin
            state_in = LG_IDLE;
         end
      endcase
   end

   always_comb begin
      done   = (state_ff == LG_DONE);
      result = {p_ff, frac_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         LG_IDLE: begin
            x_ff <= x;
            p_ff <= PW'(XW - 1);
         end
         LG_NORM: begin
            if (x_ff[XW-1]) begin
               m_ff    <= wide[XW+MANT_W-1 -: MANT_W];
               frac_ff <= '0;
               step_ff <= '0;
            end else begin
               x_ff <= x_ff << 1;
               p_ff <= p_ff - 1'b1;
            end
         end
         LG_SQ: begin
            m_ff    <= s[MANT_W] ? s[MANT_W:1] : s[MANT_W-1:0];
            frac_ff <= {frac_ff[LOG_FRAC-2:0], s[MANT_W]};
            step_ff <= step_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ rtl/kmm_back.sv @@
// ----------------------------------------------------------------------------
// kmm_back
// Count tables with read-modify-write updates, query reads and log datapath.
// ----------------------------------------------------------------------------
module kmm_back import kmm_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int HW     = 2 * MAX_WINDOW,
   localparam int SW     = (MAX_WINDOW > 1) ? 2 * (MAX_WINDOW - 1) : 1,
   localparam int OP_W   = 3 + HW + SW + 2 + QUERY_W,
   localparam int LD     = 1 << HW,
   localparam int SD     = 1 << SW,
   localparam int XW     = COUNT_BITS + 3,
   localparam int PW     = $clog2(XW),
   localparam int LOGW   = PW + LOG_FRAC,
   localparam int DLO    = 17,
   localparam int DHI    = LOGW - DLO,
   localparam int PROD_W = LOGW + LN2_W,
   localparam int RND_W  = PROD_W + 1,
   localparam int SHIFT  = LOG_FRAC + 30 - FRAC_BITS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  logic [OP_W-1:0] q_data,
   output logic            q_pop,
   output logic            clearing,
   kmm_rsp_if.source       rsp
);

   typedef struct packed {
      logic               is_query;
      logic               long_en;
      logic               short_en;
      logic [HW-1:0]      long_idx;
      logic [SW-1:0]      short_idx;
      qkind_type          qkind;
      logic [QUERY_W-1:0] qindex;
   } op_type;

   logic [COUNT_BITS-1:0] long_mem  [LD];
   logic [COUNT_BITS-1:0] short_mem [SD];

   back_state_type        state_ff, state_in;
   op_type                op_ff;
   op_type                q_op;
   logic [2:0]            cnt_ff;
   logic [XW-1:0]         sum_ff;
   logic [XW-1:0]         num_ff;
   logic [LOGW-1:0]       lnnum_ff;
   logic [LOGW-1:0]       d_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [COUNT_BITS-1:0] total_ff;
   logic [HW-1:0]         clr_ff;
   logic [COUNT_BITS-1:0] long_rdata_ff;
   logic [COUNT_BITS-1:0] short_rdata_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [QUERY_W-1:0]       rsp_index_ff;
   logic signed [LOGP_W-1:0] rsp_prob_ff;
   logic                     rsp_bad_ff;

   logic                  long_we;
   logic                  short_we;
   logic [HW-1:0]         long_waddr;
   logic [SW-1:0]         short_waddr;
   logic [COUNT_BITS-1:0] long_wdata;
   logic [COUNT_BITS-1:0] short_wdata;
   logic [HW-1:0]         long_raddr;
   logic                  lg_start;
   logic [XW-1:0]         lg_x;
   logic                  lg_done;
   logic [LOGW-1:0]       lg_result;
   logic                  rsp_load;
   logic                  rd_last;
   logic [2:0]            cnt_prev;

   logic [DLO+LN2_W-1:0]  pp_lo;
   logic [DHI+LN2_W-1:0]  pp_hi;
   logic [RND_W-1:0]      rounded;
   logic [RND_W-1:0]      shifted;
   logic [LOGP_W-1:0]     mag;

   assign q_op     = q_data;
   assign cnt_prev = cnt_ff - 3'd1;
   assign rd_last  = (op_ff.qkind == QK_INIT) ? (cnt_ff == 3'd1) : (cnt_ff == 3'd4);

   assign pp_lo   = d_ff[DLO-1:0] * LN2_Q30;
   assign pp_hi   = d_ff[LOGW-1:DLO] * LN2_Q30;
   assign rounded = RND_W'(prod_ff) + (RND_W'(1) << (SHIFT - 1));
   assign shifted = rounded >> SHIFT;
   assign mag     = (shifted > RND_W'(MAG_MAX)) ? MAG_MAX : shifted[LOGP_W-1:0];

   kmm_log #(
      .XW (XW)
   ) u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (lg_start),
      .x      (lg_x),
      .done   (lg_done),
      .result (lg_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == {HW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               if (!q_op.is_query) begin
                  state_in = ST_INC_RD;
               end else if (q_op.qkind == QK_BAD) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_Q_RD;
               end
            end
         end
         ST_INC_RD: begin
            state_in = ST_INC_WR;
         end
         ST_INC_WR: begin
            state_in = ST_IDLE;
         end
         ST_Q_RD: begin
            if (rd_last) begin
               state_in = ST_LNUM_GO;
            end
         end
         ST_LNUM_GO: begin
            state_in = ST_LNUM_WAIT;
         end
         ST_LNUM_WAIT: begin
            if (lg_done) begin
               state_in = ST_LDEN_GO;
            end
         end
         ST_LDEN_GO: begin
            state_in = ST_LDEN_WAIT;
         end
         ST_LDEN_WAIT: begin
            if (lg_done) begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      clearing    = (state_ff == ST_CLEAR);
      q_pop       = (state_ff == ST_IDLE) && !q_empty;
      lg_start    = (state_ff == ST_LNUM_GO) || (state_ff == ST_LDEN_GO);
      lg_x        = (state_ff == ST_LDEN_GO) ? sum_ff : num_ff;
      rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);
      long_raddr  = op_ff.long_idx;
      long_we     = 1'b0;
      short_we    = 1'b0;
      long_waddr  = op_ff.long_idx;
      short_waddr = op_ff.short_idx;
      long_wdata  = (long_rdata_ff == '1) ? long_rdata_ff : long_rdata_ff + 1'b1;
      short_wdata = (short_rdata_ff == '1) ? short_rdata_ff : short_rdata_ff + 1'b1;
      if (state_ff == ST_CLEAR) begin
         long_we     = 1'b1;
         short_we    = 1'b1;
         long_waddr  = clr_ff;
         short_waddr = SW'(clr_ff);
         long_wdata  = '0;
         short_wdata = '0;
      end else if (state_ff == ST_INC_WR) begin
         long_we  = op_ff.long_en;
         short_we = op_ff.short_en;
      end else if (state_ff == ST_Q_RD) begin
         long_raddr = (op_ff.long_idx & ~HW'(3)) | HW'(cnt_ff[1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (long_we) begin
         long_mem[long_waddr] <= long_wdata;
      end
      long_rdata_ff <= long_mem[long_raddr];
   end

   always_ff @(posedge clock) begin
      if (short_we) begin
         short_mem[short_waddr] <= short_wdata;
      end
      short_rdata_ff <= short_mem[op_ff.short_idx];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if ((state_ff == ST_INC_WR) && op_ff.short_en && (total_ff != '1)) begin
            total_ff <= total_ff + 1'b1;
         end
         if (q_pop) begin
            cnt_ff <= '0;
         end else if (state_ff == ST_Q_RD) begin
            cnt_ff <= cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff  <= q_op;
         sum_ff <= XW'(4);
      end
      if ((state_ff == ST_Q_RD) && (cnt_ff != 3'd0)) begin
         if (op_ff.qkind == QK_INIT) begin
            num_ff <= XW'(short_rdata_ff) + XW'(1);
            sum_ff <= XW'(total_ff) + XW'(1);
         end else begin
            sum_ff <= sum_ff + XW'(long_rdata_ff);
            if (cnt_prev[1:0] == op_ff.long_idx[1:0]) begin
               num_ff <= XW'(long_rdata_ff) + XW'(1);
            end
         end
      end
      if ((state_ff == ST_LNUM_WAIT) && lg_done) begin
         lnnum_ff <= lg_result;
      end
      if ((state_ff == ST_LDEN_WAIT) && lg_done) begin
         d_ff <= (lg_result > lnnum_ff) ? lg_result - lnnum_ff : '0;
      end
      if (state_ff == ST_MUL_LO) begin
         prod_ff <= PROD_W'(pp_lo);
      end
      if (state_ff == ST_MUL_HI) begin
         prod_ff <= prod_ff + (PROD_W'(pp_hi) << DLO);
      end
      if (rsp_load) begin
         rsp_index_ff <= op_ff.qindex;
         rsp_bad_ff   <= (op_ff.qkind == QK_BAD);
         rsp_prob_ff  <= (op_ff.qkind == QK_BAD) ? '0 : LOGP_W'(0) - mag;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.entry_index = rsp_index_ff;
   assign rsp.log_prob    = rsp_prob_ff;
   assign rsp.bad_index   = rsp_bad_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("loaded response not presented");

   a_log_done_wait: assert property (@(posedge clock) disable iff (reset)
      lg_done |-> (state_ff == ST_LNUM_WAIT || state_ff == ST_LDEN_WAIT))
      else $error("log result with nobody waiting");

   a_no_bad_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_RD) |-> (op_ff.qkind != QK_BAD))
      else $error("table read for an out-of-range query");

endmodule

@@ tb/tb_kmm_scoreboard.sv @@
// ----------------------------------------------------------------------------
// tb_kmm_scoreboard
// Predicts k-mer window counts and log-probability answers of the trainer and
// checks every response beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package tb_kmm_sb_pkg;
   import kmm_pkg::*;

   typedef struct packed {
      logic [QUERY_W-1:0]       entry_index;
      logic signed [LOGP_W-1:0] log_prob;
      logic                     bad_index;
   } answer_type;

   class kmm_model_checker;
      localparam int WIN = MAX_WINDOW_DEF;
      longint unsigned long_cnt [4096];
      longint unsigned short_cnt [1024];
      longint unsigned short_total;
      logic [11:0] history;
      int unsigned run_len;
      phase_type phase;
      logic [ORDER_W-1:0] order_reg;
      answer_type pending [$];
      int errors;

      function new();
         foreach (long_cnt[k]) long_cnt[k] = 0;
         foreach (short_cnt[k]) short_cnt[k] = 0;
         short_total = 0;
         history = '0;
         run_len = 0;
         phase = PH_FIRST;
         order_reg = ORDER_RESET;
         errors = 0;
      endfunction

      function int unsigned order_now();
         return (order_reg > WIN - 1) ? WIN - 1 : order_reg;
      endfunction

      function void bump(ref longint unsigned c);
         if (c < 64'hFFFF_FFFF) c++;
      endfunction

      function void add_base(logic [1:0] b);
         int unsigned o;
         o = order_now();
         history = {history[9:0], b};
         if (run_len < WIN) run_len++;
         if (run_len >= o + 1) bump(long_cnt[history & ((1 << (2 * (o + 1))) - 1)]);
         if (o >= 1 && run_len >= o) begin
            bump(short_cnt[history & ((1 << (2 * o)) - 1)]);
            bump(short_total);
         end
      endfunction

      function void take_byte(logic [7:0] ch);
         if (phase == PH_FIRST) begin
            phase = (ch == HDR_CHAR) ? PH_HEADER : PH_SEQ;
            return;
         end
         if (phase == PH_HEADER) begin
            if (ch == NL_CHAR) phase = PH_SEQ;
            return;
         end
         case (ch)
            "A", "a": add_base(2'd0);
            "T", "t": add_base(2'd1);
            "G", "g": add_base(2'd2);
            "C", "c": add_base(2'd3);
            "N", "n": run_len = 0;
            default: ;
         endcase
      endfunction

      function longint unsigned log2_q28(longint unsigned x);
         int unsigned p;
         longint unsigned t, m, fr;
         p = 0;
         t = x;
         fr = 0;
         if (x == 0) return 0;
         while (t > 1) begin
            t >>= 1;
            p++;
         end
         m = (p > 30) ? (x >> (p - 30)) : (x << (30 - p));
         for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> 30;
            fr <<= 1;
            if (m >= (64'd1 << 31)) begin
               m >>= 1;
               fr |= 1;
            end
         end
         return (longint'(p) << LOG_FRAC) | fr;
      endfunction

      function longint unsigned ln_magnitude(longint unsigned num, longint unsigned den);
         longint unsigned a, b, d, r;
         int unsigned sh;
         a = log2_q28(num);
         b = log2_q28(den);
         sh = LOG_FRAC + 30 - FRAC_BITS_DEF;
         if (b <= a) return 0;
         d = b - a;
         r = (d * 64'd744261118 + (64'd1 << (sh - 1))) >> sh;
         return (r > 64'h200000) ? 64'h200000 : r;
      endfunction

      function void note_request(logic cmd, logic [7:0] fb, logic [QUERY_W-1:0] qi);
         answer_type ans;
         int unsigned o;
         longint unsigned nl, ns, num, den, g, mag;
         if (cmd == CMD_BYTE) begin
            take_byte(fb);
            return;
         end
         o = order_now();
         nl = 64'd1 << (2 * (o + 1));
         ns = 64'd1 << (2 * o);
         ans.entry_index = qi;
         ans.bad_index = 1'b0;
         if (qi < nl) begin
            g = qi & ~64'd3;
            num = long_cnt[qi] + 1;
            den = long_cnt[g] + long_cnt[g+1] + long_cnt[g+2] + long_cnt[g+3] + 4;
         end else if (o >= 1 && qi < nl + ns) begin
            num = short_cnt[qi - nl] + 1;
            den = short_total + 1;
         end else begin
            ans.log_prob = '0;
            ans.bad_index = 1'b1;
            pending.push_back(ans);
            return;
         end
         mag = ln_magnitude(num, den);
         ans.log_prob = LOGP_W'(64'h400000 - mag);
         pending.push_back(ans);
      endfunction

      function void check_answer(answer_type got);
         answer_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat: idx %0d", got.entry_index);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp idx %0d logp %0d bad %0b, got idx %0d logp %0d bad %0b",
                        want.entry_index, want.log_prob, want.bad_index,
                        got.entry_index, got.log_prob, got.bad_index);
         end
      endfunction
   endclass
endpackage

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives FASTA bytes and table queries into the k-mer Markov trainer over
// several Markov orders, with random idling and long back-pressure, and
// compares every response with the scoreboard prediction.
// ----------------------------------------------------------------------------
module tb;
   import kmm_pkg::*;
   import tb_kmm_sb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   kmm_req_if req_chan ();
   kmm_rsp_if rsp_chan ();

   kmer_markov_model_trainer_core i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   kmm_model_checker model = new();
   bit idle_on = 1;
   bit hold_rsp = 0;
   int quiet_cycles = 0;
   string directed_seq = "ACGTacgtNnGG";

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // watchdog and response checking
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_chan.valid && rsp_chan.ready)
            model.check_answer({rsp_chan.entry_index, rsp_chan.log_prob, rsp_chan.bad_index});
         if (quiet_cycles > STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= !hold_rsp && !(idle_on && $urandom_range(99) < 12);
   end

   task automatic write_order(int unsigned val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(CSR_SEL_ORDER);
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      model.order_reg = ORDER_W'(val);
   endtask

   task automatic send_beat(logic cmd, logic [7:0] fb, logic [QUERY_W-1:0] qi);
      while (idle_on && $urandom_range(99) < 12) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd <= cmd;
      req_chan.file_byte <= fb;
      req_chan.query_index <= qi;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      model.note_request(cmd, fb, qi);
   endtask

   task automatic go_quiet();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (model.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [7:0] base_char();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? "A" : "a";
         1: return $urandom_range(1) ? "T" : "t";
         2: return $urandom_range(1) ? "G" : "g";
         default: return $urandom_range(1) ? "C" : "c";
      endcase
   endfunction

   function automatic logic [7:0] seq_char();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 80) return base_char();
      if (r < 86) return $urandom_range(1) ? "N" : "n";
      if (r < 92) return NL_CHAR;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_query();
      int unsigned o, span;
      o = (model.order_reg > 5) ? 5 : model.order_reg;
      span = (1 << (2 * (o + 1))) + ((o >= 1) ? (1 << (2 * o)) : 0);
      if ($urandom_range(19) == 0)
         send_beat(CMD_QUERY, 8'($urandom), QUERY_W'($urandom_range(8191)));
      else
         send_beat(CMD_QUERY, 8'($urandom), QUERY_W'($urandom_range(span + 2)));
   endtask

   task automatic random_phase(int unsigned beats);
      for (int i = 0; i < beats; i++) begin
         if ($urandom_range(99) < 15) send_query();
         else send_beat(CMD_BYTE, seq_char(), QUERY_W'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cmd = CMD_BYTE;
      req_chan.file_byte = '0;
      req_chan.query_index = '0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: header, bases of both cases, break, extremes of queries
      send_beat(CMD_BYTE, HDR_CHAR, '0);
      send_beat(CMD_BYTE, "x", '1);
      send_beat(CMD_BYTE, NL_CHAR, '0);
      foreach (directed_seq[k]) send_beat(CMD_BYTE, directed_seq[k], '0);
      send_beat(CMD_BYTE, 8'hFF, '0);
      send_beat(CMD_QUERY, 8'h00, 13'd0);
      send_beat(CMD_QUERY, 8'hFF, 13'd63);
      send_beat(CMD_QUERY, 8'h00, 13'd64);
      send_beat(CMD_QUERY, 8'h00, 13'd79);
      send_beat(CMD_QUERY, 8'h00, 13'd80);
      send_beat(CMD_QUERY, 8'h00, 13'd8191);
      send_beat(CMD_QUERY, 8'h00, 13'd5119);
      go_quiet();

      write_order(0);
      random_phase(100);
      send_beat(CMD_QUERY, 8'h00, 13'd4);
      go_quiet();

      // back-pressure: hold the receiver while requests keep coming
      fork
         begin
            hold_rsp = 1;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 12; i++) send_query();
      join
      go_quiet();

      write_order(5);
      random_phase(150);
      go_quiet();
      write_order(7);
      random_phase(100);
      go_quiet();
      write_order(1);
      idle_on = 0;
      random_phase(120);
      idle_on = 1;
      go_quiet();
      write_order(3);
      random_phase(150);
      go_quiet();
      write_order(2);
      random_phase(100);
      go_quiet();

      if (model.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
